// ===== rtl/custom_16bit_cpu_execute_step_assert.svh =====
// Assertion macros shared by the execute step RTL.
`ifndef CUSTOM_16BIT_CPU_EXECUTE_STEP_ASSERT_SVH
`define CUSTOM_16BIT_CPU_EXECUTE_STEP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define C16X_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define C16X_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/c16x_pkg.sv =====
package c16x_pkg;

    // Sizes and reset values
    localparam int          C16X_MEM_WORDS  = 1024;
    localparam int          C16X_Q_DEPTH    = 2;
    localparam int          C16X_IN_W       = 16;
    localparam int          C16X_OUT_W      = 72;
    localparam logic [15:0] C16X_PLEN_RESET = 16'hFFFF;
    localparam logic [3:0]  C16X_PC_IDX     = 4'd15;

    // Shift sub-modes (low two bits of X)
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_ROT = 2'd1;
    localparam logic [1:0] SH_LSR = 2'd2;
    localparam logic [1:0] SH_ASR = 2'd3;

    // Rotate kinds ({I, X[2]})
    localparam logic [1:0] ROT_L1 = 2'd0;
    localparam logic [1:0] ROT_L2 = 2'd1;
    localparam logic [1:0] ROT_R1 = 2'd2;
    localparam logic [1:0] ROT_R2 = 2'd3;

    typedef enum logic [3:0] {
        OP_SHIFT = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_AND   = 4'd3,
        OP_NOT   = 4'd4,
        OP_LD    = 4'd5,
        OP_BRA   = 4'd6,
        OP_BEQ   = 4'd7,
        OP_BNE   = 4'd8,
        OP_BGT   = 4'd9,
        OP_BGE   = 4'd10,
        OP_BLT   = 4'd11,
        OP_BLE   = 4'd12,
        OP_LLI   = 4'd13,
        OP_LUI   = 4'd14,
        OP_ST    = 4'd15
    } t_opc;

    // Decoded instruction as it travels through the queue
    typedef struct packed {
        t_opc       opc;
        logic [3:0] d;
        logic       ib;
        logic [3:0] a;
        logic [2:0] x;
        logic       is_mem;
        logic       is_load;
    } t_uop;

    // One result item; next_pc sits in the lowest bits
    typedef struct packed {
        logic        halted;
        logic [15:0] mem_value;
        logic [9:0]  mem_address;
        logic        mem_write;
        logic [15:0] reg_value;
        logic [3:0]  reg_index;
        logic        reg_write;
        logic [15:0] next_pc;
    } t_result;

    // Back-end status seen by the top level
    typedef struct packed {
        logic clearing;
        logic halted;
    } t_ex_status;

endpackage

// ===== rtl/c16x_front.sv =====
module c16x_front (
    input  logic                 i_valid,
    input  logic [15:0]          i_data,
    output logic                 o_ready,
    input  logic                 i_q_full,
    output logic                 o_push,
    output c16x_pkg::t_uop       o_uop
);
    import c16x_pkg::*;

    t_opc opc;

    // Take a beat whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Split fields and classify memory operations
    always_comb begin
        opc           = t_opc'(i_data[15:12]);
        o_uop.opc     = opc;
        o_uop.d       = i_data[11:8];
        o_uop.ib      = i_data[7];
        o_uop.a       = i_data[6:3];
        o_uop.x       = i_data[2:0];
        o_uop.is_mem  = (opc == OP_LD) || (opc == OP_ST);
        o_uop.is_load = (opc == OP_LD);
    end

endmodule

// ===== rtl/c16x_queue.sv =====
module c16x_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  c16x_pkg::t_uop       i_uop,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output c16x_pkg::t_uop       o_uop
);
    import c16x_pkg::*;

    localparam int QAW = (C16X_Q_DEPTH > 1) ? $clog2(C16X_Q_DEPTH) : 1;

    t_uop             r_slot [C16X_Q_DEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(C16X_Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_uop   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QAW'(C16X_Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QAW'(C16X_Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold entries; no reset on payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_uop;
        end
    end

endmodule

// ===== rtl/c16x_back.sv =====
module c16x_back #(
    parameter int MEM_WORDS = c16x_pkg::C16X_MEM_WORDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_q_valid,
    input  c16x_pkg::t_uop        i_q_uop,
    output logic                  o_q_pop,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output c16x_pkg::t_result     o_out,
    output c16x_pkg::t_ex_status  o_status
);
    import c16x_pkg::*;

    // Address reduction by multiply with a reciprocal (exact for 17-bit sums)
    localparam int             AW     = $clog2(MEM_WORDS);
    localparam int             SH     = 17 + AW;
    localparam longint         RECIPL = ((64'(1) << SH) + MEM_WORDS - 1) / MEM_WORDS;
    localparam int             RW     = $clog2(RECIPL + 1);
    localparam int             PW     = 17 + RW;
    localparam logic [RW-1:0]  RECIP  = RW'(RECIPL);
    localparam logic [16:0]    MW17   = 17'(MEM_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_EXEC  = 4'b0010,
        S_ADDR  = 4'b0100,
        S_LOAD  = 4'b1000
    } t_ex_state;

    // Architectural state
    logic [15:0]   r_rf [15];
    logic [15:0]   r_pc, n_pc;
    logic          r_halt, n_halt;
    logic [15:0]   r_plen;
    logic [15:0]   r_mem [MEM_WORDS];
    logic [15:0]   r_mq;

    // Operand stage
    logic          r_rr_valid, n_rr_valid;
    t_uop          r_rr_uop;
    logic [15:0]   r_rr_rd, n_rr_rd;
    logic [15:0]   r_rr_ra, n_rr_ra;

    // Sequencer
    t_ex_state     r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [16:0]   r_v, n_v;
    logic [PW-1:0] r_prod, n_prod;

    // Output register
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          can_emit;
    logic          done;
    logic          emit;
    logic [15:0]   rd;
    logic [15:0]   ra;
    logic [6:0]    imm7;
    logic [1:0]    ix;
    logic [15:0]   exe_res;
    logic          exe_wreg;
    logic          exe_jump;
    logic [15:0]   exe_off;
    logic          neg;
    logic          zero;
    logic [15:0]   exe_npc;
    logic [15:0]   pc1;
    logic [16:0]   q;
    logic [33:0]   qm;
    logic [16:0]   maddr;
    logic          fin_wreg;
    logic [15:0]   fin_res;
    logic          fin_mw;
    logic [15:0]   fin_npc;
    logic          rf_we;
    logic [3:0]    rf_widx;
    logic          mem_we;
    logic [AW-1:0] mem_widx;
    logic [15:0]   mem_wdata;
    logic          mem_re;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.halted   = r_halt;

    assign can_emit = !r_out_valid || i_out_ready;
    assign rd   = (r_rr_uop.d == C16X_PC_IDX) ? r_pc : r_rr_rd;
    assign ra   = (r_rr_uop.a == C16X_PC_IDX) ? r_pc : r_rr_ra;
    assign imm7 = {r_rr_uop.a, r_rr_uop.x};
    assign ix   = {r_rr_uop.ib, r_rr_uop.x[2]};
    assign pc1  = r_pc + 16'd1;
    assign neg  = rd[15];
    assign zero = (rd == 16'd0);

    // Combinational ALU, shift and branch operations
    always_comb begin
        exe_res  = 16'd0;
        exe_wreg = 1'b0;
        exe_jump = 1'b0;
        exe_off  = 16'd0;
        unique case (r_rr_uop.opc)
            OP_SHIFT: begin
                exe_wreg = 1'b1;
                unique case (r_rr_uop.x[1:0])
                    SH_LSL: exe_res = ra << (3'(ix) + 3'd1);
                    SH_LSR: exe_res = ra >> (3'(ix) + 3'd1);
                    SH_ROT: begin
                        unique case (ix)
                            ROT_L1: exe_res = {ra[14:0], ra[15]};
                            ROT_L2: exe_res = {ra[13:0], ra[15:14]};
                            ROT_R1: exe_res = {ra[0], ra[15:1]};
                            ROT_R2: exe_res = {ra[1:0], ra[15:2]};
                        endcase
                    end
                    SH_ASR: exe_res = {ra[15], ra[15:1]};
                endcase
            end
            OP_ADD: begin
                exe_wreg = 1'b1;
                exe_res  = rd + (r_rr_uop.ib ? {9'd0, imm7} : ra);
            end
            OP_SUB: begin
                exe_wreg = 1'b1;
                exe_res  = rd - (r_rr_uop.ib ? {9'd0, imm7} : ra);
            end
            OP_AND: begin
                exe_wreg = 1'b1;
                exe_res  = rd & ra;
            end
            OP_NOT: begin
                exe_wreg = 1'b1;
                exe_res  = ~ra;
            end
            OP_LD, OP_ST: begin
                exe_wreg = 1'b0;
            end
            OP_BRA: begin
                exe_jump = 1'b1;
                exe_off  = {5'd0, r_rr_uop.d, imm7};
            end
            OP_BEQ: exe_jump = zero;
            OP_BNE: exe_jump = !zero;
            OP_BGT: exe_jump = !neg && !zero;
            OP_BGE: exe_jump = !neg;
            OP_BLT: exe_jump = neg;
            OP_BLE: exe_jump = neg || zero;
            OP_LLI: begin
                exe_wreg = 1'b1;
                exe_res  = {8'd0, r_rr_uop.ib, imm7};
            end
            OP_LUI: begin
                exe_wreg = 1'b1;
                exe_res  = rd + {r_rr_uop.ib, imm7, 8'd0};
            end
        endcase
        if (exe_jump && (r_rr_uop.opc != OP_BRA)) begin
            exe_off = {9'd0, imm7};
        end
    end

    assign exe_npc = (exe_jump ? (r_rr_uop.ib ? r_pc - exe_off : r_pc + exe_off) : r_pc)
                     + 16'd1;

    // Reduce the registered sum modulo the memory size
    assign q     = 17'(r_prod >> SH);
    assign qm    = 34'(q) * 34'(MW17);
    assign maddr = r_v - qm[16:0];

    // Sequence one instruction at a time through the back end
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_v       = r_v;
        n_prod    = r_prod;
        done      = 1'b0;
        emit      = 1'b0;
        fin_wreg  = 1'b0;
        fin_res   = 16'd0;
        fin_mw    = 1'b0;
        fin_npc   = pc1;
        mem_we    = 1'b0;
        mem_widx  = maddr[AW-1:0];
        mem_wdata = rd;
        mem_re    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_widx  = r_clr;
                mem_wdata = 16'd0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(MEM_WORDS - 1)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_rr_valid) begin
                    if (r_halt) begin
                        if (can_emit) begin
                            done = 1'b1;
                            emit = 1'b1;
                        end
                    end else if (r_rr_uop.is_mem) begin
                        n_v     = r_rr_uop.ib ? 17'(imm7) : 17'(ra) + 17'(r_rr_uop.x);
                        n_prod  = PW'(n_v) * PW'(RECIP);
                        n_state = S_ADDR;
                    end else if (can_emit) begin
                        done     = 1'b1;
                        emit     = 1'b1;
                        fin_wreg = exe_wreg;
                        fin_res  = exe_res;
                        fin_npc  = exe_npc;
                    end
                end
            end
            S_ADDR: begin
                if (r_rr_uop.is_load) begin
                    mem_re  = 1'b1;
                    n_state = S_LOAD;
                end else if (can_emit) begin
                    mem_we  = 1'b1;
                    done    = 1'b1;
                    emit    = 1'b1;
                    fin_mw  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_LOAD: begin
                if (can_emit) begin
                    done     = 1'b1;
                    emit     = 1'b1;
                    fin_wreg = 1'b1;
                    fin_res  = r_mq;
                    n_state  = S_EXEC;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Retire: state updates and the result beat
    always_comb begin
        rf_we   = emit && !r_halt && fin_wreg && (r_rr_uop.d != C16X_PC_IDX);
        rf_widx = r_rr_uop.d;
        n_pc    = r_pc;
        n_halt  = r_halt;
        n_out   = r_out;
        if (emit) begin
            n_out = '0;
            if (r_halt) begin
                n_out.next_pc = r_pc;
                n_out.halted  = 1'b1;
            end else begin
                n_pc   = fin_npc;
                n_halt = (fin_npc == r_plen);
                n_out.next_pc = fin_npc;
                n_out.halted  = (fin_npc == r_plen);
                if (rf_we) begin
                    n_out.reg_write = 1'b1;
                    n_out.reg_index = r_rr_uop.d;
                    n_out.reg_value = fin_res;
                end
                if (fin_mw) begin
                    n_out.mem_write   = 1'b1;
                    n_out.mem_address = maddr[9:0];
                    n_out.mem_value   = rd;
                end
            end
        end
        n_out_valid = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // Refill the operand stage, forwarding a write of the same edge
    assign o_q_pop = i_q_valid && (!r_rr_valid || done);

    always_comb begin
        n_rr_valid = o_q_pop ? 1'b1 : (done ? 1'b0 : r_rr_valid);
        n_rr_rd    = r_rr_rd;
        n_rr_ra    = r_rr_ra;
        if (o_q_pop) begin
            if (rf_we && (rf_widx == i_q_uop.d)) begin
                n_rr_rd = fin_res;
            end else if (i_q_uop.d == C16X_PC_IDX) begin
                n_rr_rd = 16'd0;
            end else begin
                n_rr_rd = r_rf[i_q_uop.d];
            end
            if (rf_we && (rf_widx == i_q_uop.a)) begin
                n_rr_ra = fin_res;
            end else if (i_q_uop.a == C16X_PC_IDX) begin
                n_rr_ra = 16'd0;
            end else begin
                n_rr_ra = r_rf[i_q_uop.a];
            end
        end
    end

    // Control and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= 16'd0;
            r_halt      <= 1'b0;
            r_plen      <= C16X_PLEN_RESET;
            r_rr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 15; i++) begin
                r_rf[i] <= 16'd0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_rr_valid  <= n_rr_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_plen <= i_cfg_data;
            end
            if (rf_we) begin
                r_rf[rf_widx] <= fin_res;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_prod  <= n_prod;
        r_out   <= n_out;
        r_rr_rd <= n_rr_rd;
        r_rr_ra <= n_rr_ra;
        if (o_q_pop) begin
            r_rr_uop <= i_q_uop;
        end
    end

    // Data memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_widx] <= mem_wdata;
        end
        if (mem_re) begin
            r_mq <= r_mem[maddr[AW-1:0]];
        end
    end

endmodule

// ===== rtl/custom_16bit_cpu_execute_step.sv =====
// Path from input beat to result beat: instruction queue, operand stage, result register
// for ALU, shift and branch instructions; a store adds the address state (reciprocal address
// reduction), a load adds that plus the registered read of the data memory. Throughput: one
// instruction per cycle while m_tready allows; a store or load holds the back end until done.
// Reset (synchronous, active low) clears registers, PC and halt flag, then sweeps
// the data memory to zero; no result is given during the sweep.
module custom_16bit_cpu_execute_step #(
    parameter int MEM_WORDS = c16x_pkg::C16X_MEM_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: program_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // Instruction stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // instruction[15:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[15:0], reg_write[16], reg_index[20:17], reg_value[36:21],
    // mem_write[37], mem_address[47:38], mem_value[63:48], halted[64], zero[71:65]
    output logic [71:0] m_tdata
);
    import c16x_pkg::*;

    logic       q_full;
    logic       push;
    t_uop       f_uop;
    logic       q_valid;
    t_uop       q_uop;
    logic       q_pop;
    t_result    res;
    t_ex_status status;

    assign o_cfg_ready = 1'b1;

    c16x_front u_front (
        .i_valid  (s_tvalid),
        .i_data   (s_tdata),
        .o_ready  (s_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_uop    (f_uop)
    );

    c16x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (f_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_uop   (q_uop)
    );

    c16x_back #(
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_uop     (q_uop),
        .o_q_pop     (q_pop),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out       (res),
        .o_status    (status)
    );

    assign m_tdata = {(C16X_OUT_W - $bits(t_result))'(0), res};

`include "custom_16bit_cpu_execute_step_assert.svh"

    `C16X_ASSERT_CLK(a_no_beat_in_clear, status.clearing |-> !m_tvalid, "result during memory clear")
    `C16X_ASSERT_CLK(a_halt_shown, (status.halted && m_tvalid) |-> m_tdata[64], "halt flag not in beat")
    `C16X_ASSERT_CLK(a_no_pc_write, (m_tvalid && m_tdata[16]) |-> (m_tdata[20:17] != C16X_PC_IDX), "write to PC index")
    `C16X_ASSERT_ALWAYS(a_one_write, m_tvalid |-> !(m_tdata[16] && m_tdata[37]), "register and memory write together")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import c16x_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // instruction[15:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // next_pc, reg_write, reg_index, reg_value, mem_write, mem_address, mem_value, halted
    logic [71:0] m_tdata;

    // Shadow machine state
    logic [15:0] gpr [15];
    logic [15:0] mem_shadow [C16X_MEM_WORDS];
    logic [15:0] pc_shadow;
    logic        halt_shadow;
    logic [15:0] plen_shadow;

    t_result     pending_results [$];
    int          errors = 0;
    bit          steady_flow = 1'b0;
    int          stall_req = 0;
    int          stall_seen = 0;
    int          stall_cnt = 0;
    int          quiet_cycles = 0;

    custom_16bit_cpu_execute_step uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Encode one instruction word
    function automatic logic [15:0] enc(t_opc op, int d, int ib, int a, int x);
        return {op, d[3:0], ib[0], a[3:0], x[2:0]};
    endfunction

    // Work out the result of one instruction from the shadow state
    function automatic t_result exec_word(logic [15:0] w);
        t_result     r;
        t_opc        op;
        logic [3:0]  d, a;
        logic        ib;
        logic [2:0]  x;
        logic [6:0]  imm7;
        logic [1:0]  ix;
        logic [15:0] rd, ra, res, pc, offset;
        logic [9:0]  maddr;
        logic        wreg, jump, taken;
        r = '0;
        if (halt_shadow) begin
            r.next_pc = pc_shadow;
            r.halted = 1'b1;
            return r;
        end
        op = t_opc'(w[15:12]);
        d = w[11:8];
        ib = w[7];
        a = w[6:3];
        x = w[2:0];
        imm7 = w[6:0];
        rd = (d == C16X_PC_IDX) ? pc_shadow : gpr[d];
        ra = (a == C16X_PC_IDX) ? pc_shadow : gpr[a];
        maddr = ib ? 10'(imm7) : 10'(ra + x);
        pc = pc_shadow;
        res = '0;
        offset = '0;
        wreg = 1'b1;
        jump = 1'b0;
        taken = 1'b0;
        case (op)
            OP_SHIFT: begin
                ix = {ib, x[2]};
                case (x[1:0])
                    SH_LSL: res = ra << (ix + 1);
                    SH_LSR: res = ra >> (ix + 1);
                    SH_ROT: begin
                        case (ix)
                            ROT_L1: res = {ra[14:0], ra[15]};
                            ROT_L2: res = {ra[13:0], ra[15:14]};
                            ROT_R1: res = {ra[0], ra[15:1]};
                            default: res = {ra[1:0], ra[15:2]};
                        endcase
                    end
                    default: res = {ra[15], ra[15:1]};
                endcase
            end
            OP_ADD: res = rd + (ib ? 16'(imm7) : ra);
            OP_SUB: res = rd - (ib ? 16'(imm7) : ra);
            OP_AND: res = rd & ra;
            OP_NOT: res = ~ra;
            OP_LD:  res = mem_shadow[maddr];
            OP_LLI: res = {8'd0, ib, imm7};
            OP_LUI: res = rd + {ib, imm7, 8'd0};
            OP_BRA: begin
                wreg = 1'b0;
                jump = 1'b1;
                offset = {5'd0, d, imm7};
            end
            OP_ST: begin
                wreg = 1'b0;
                r.mem_write = 1'b1;
                r.mem_address = maddr;
                r.mem_value = rd;
            end
            default: begin
                wreg = 1'b0;
                case (op)
                    OP_BEQ: taken = (rd == 0);
                    OP_BNE: taken = (rd != 0);
                    OP_BGT: taken = ($signed(rd) > 0);
                    OP_BGE: taken = ($signed(rd) >= 0);
                    OP_BLT: taken = ($signed(rd) < 0);
                    default: taken = ($signed(rd) <= 0);
                endcase
                jump = taken;
                offset = 16'(imm7);
            end
        endcase
        if (jump) pc = ib ? pc - offset : pc + offset;
        pc = pc + 16'd1;
        if (wreg && d != C16X_PC_IDX) begin
            r.reg_write = 1'b1;
            r.reg_index = d;
            r.reg_value = res;
        end
        r.next_pc = pc;
        r.halted = (pc == plen_shadow);
        return r;
    endfunction

    // Fold one result into the shadow state
    task automatic commit(t_result r);
        if (r.reg_write) gpr[r.reg_index] = r.reg_value;
        if (r.mem_write) mem_shadow[r.mem_address] = r.mem_value;
        pc_shadow = r.next_pc;
        halt_shadow = r.halted;
    endtask

    // Offer one instruction beat, idling at random before it
    task automatic send_instr(logic [15:0] w);
        t_result r;
        if (!steady_flow && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge i_clk); while (!s_tready);
        r = exec_word(w);
        pending_results.push_back(r);
        commit(r);
    endtask

    // Drop valid and let the pipeline drain
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_plen(logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        plen_shadow = v;
    endtask

    // Random instruction that does not stop the machine
    function automatic logic [15:0] random_instr;
        logic [15:0] w;
        t_result     r;
        do begin
            w = 16'($urandom);
            // keep memory traffic in a small window so loads see stores
            if ((w[15:12] == OP_LD || w[15:12] == OP_ST) && $urandom_range(1)) w[7] = 1'b1;
            r = exec_word(w);
        end while (r.halted);
        return w;
    endfunction

    function automatic logic [15:0] random_instr_any;
        return 16'($urandom);
    endfunction

    task automatic test_directed;
        send_instr(enc(OP_LLI, 1, 1, 15, 7));      // r1 = 0x00FF
        send_instr(enc(OP_LUI, 1, 1, 15, 7));      // r1 = 0xFFFF
        send_instr(enc(OP_LLI, 2, 1, 0, 0));       // r2 = 0x0080
        send_instr(enc(OP_SHIFT, 3, 1, 1, 4));     // LSL by 4
        send_instr(enc(OP_SHIFT, 3, 0, 1, 2));     // LSR by 1
        send_instr(enc(OP_SHIFT, 4, 1, 2, 6));     // LSR by 4
        send_instr(enc(OP_SHIFT, 4, 0, 2, 1));     // rotate left 1
        send_instr(enc(OP_SHIFT, 4, 0, 2, 5));     // rotate left 2
        send_instr(enc(OP_SHIFT, 5, 1, 2, 1));     // rotate right 1
        send_instr(enc(OP_SHIFT, 5, 1, 2, 5));     // rotate right 2
        send_instr(enc(OP_SHIFT, 6, 0, 1, 3));     // arithmetic right
        send_instr(enc(OP_ADD, 1, 1, 15, 7));      // wraps past 0xFFFF
        send_instr(enc(OP_SUB, 7, 0, 1, 0));       // 0 - r1
        send_instr(enc(OP_AND, 1, 0, 2, 0));
        send_instr(enc(OP_NOT, 8, 0, 15, 0));      // reads the PC
        send_instr(enc(OP_ST, 8, 1, 15, 7));       // store to address 127
        send_instr(enc(OP_LD, 9, 1, 15, 7));
        send_instr(enc(OP_NOT, 10, 0, 0, 0));      // r10 = 0xFFFF
        send_instr(enc(OP_ST, 2, 0, 10, 7));       // address wraps to 6
        send_instr(enc(OP_LD, 11, 0, 10, 7));
        send_instr(enc(OP_LLI, 15, 1, 3, 3));      // write to the PC is dropped
        send_instr(enc(OP_BRA, 15, 0, 15, 7));     // far forward
        send_instr(enc(OP_BRA, 15, 1, 15, 7));     // far backward
        for (int op = OP_BEQ; op <= OP_BLE; op++) begin
            send_instr(enc(t_opc'(op), 10, op[0], 15, 7));
        end
        send_instr(enc(OP_BLE, 0, 0, 3, 1));
        send_instr(enc(OP_BGT, 2, 1, 0, 5));
    endtask

    task automatic test_random(int n, bit steady);
        steady_flow = steady;
        for (int k = 0; k < n; k++) send_instr(random_instr());
        steady_flow = 1'b0;
    endtask

    task automatic test_backpressure;
        stall_req++;
        for (int k = 0; k < 40; k++) send_instr(random_instr());
    endtask

    task automatic test_halt;
        logic [15:0] target;
        target = pc_shadow + 16'd3;
        if (target == 0) target = 16'd1;
        write_plen(target);
        while (!halt_shadow) send_instr(enc(OP_ADD, 3, 1, 0, 1));
        for (int k = 0; k < 6; k++) send_instr(random_instr_any());
    endtask

    // Receiver: random idling, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_cnt <= 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(99) >= 26);
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // Compare every result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[64:0]);
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $realtime, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", want.next_pc, got.next_pc);
                check_field("reg_write", 16'(want.reg_write), 16'(got.reg_write));
                check_field("reg_index", 16'(want.reg_index), 16'(got.reg_index));
                check_field("reg_value", want.reg_value, got.reg_value);
                check_field("mem_write", 16'(want.mem_write), 16'(got.mem_write));
                check_field("mem_address", 16'(want.mem_address), 16'(got.mem_address));
                check_field("mem_value", want.mem_value, got.mem_value);
                check_field("halted", 16'(want.halted), 16'(got.halted));
            end
        end
    end

    // Watchdog on cycles with no beat anywhere
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 15; k++) gpr[k] = '0;
        for (int k = 0; k < C16X_MEM_WORDS; k++) mem_shadow[k] = '0;
        pc_shadow = '0;
        halt_shadow = 1'b0;
        plen_shadow = C16X_PLEN_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_plen(16'd1);
        test_random(300, 1'b0);
        write_plen(16'hFFFF);
        test_random(250, 1'b1);
        test_backpressure();
        write_plen(16'($urandom_range(1, 65535)));
        test_random(360, 1'b0);
        test_halt();
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
